FILE: design/iobt_pkg.sv
// ----------------------------------------------------------------------------
// iobt_pkg
// Shared types and codes for the interval overlap booking table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iobt_pkg;

    localparam int FIELD_BITS = 32;

    typedef struct packed {
        logic [FIELD_BITS-1:0] start_time;
        logic [FIELD_BITS-1:0] end_time;
    } req_t;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_OVERLAP = 2'd1;
    localparam status_t STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic    accepted;
        status_t status;
    } rsp_t;

endpackage

FILE: design/interval_overlap_booking_table.sv
// ----------------------------------------------------------------------------
// interval_overlap_booking_table
// Requests: s_ready is high only in S_IDLE, so a new request is not taken
// until the previous decision has been issued. In the request cycle every cell
// compares the request against its slot; in S_DECIDE, once no result is still
// waiting on m_ready, the hits are combined, the response is registered and an
// accepted interval shifts into the head of the cell chain.
// Reset: all slots become empty at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_overlap_booking_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  iobt_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output iobt_pkg::rsp_t m_data
);

    import iobt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_DECIDE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [TIME_BITS-1:0] in_start;
    logic [TIME_BITS-1:0] in_end;
    logic [TIME_BITS-1:0] req_start_reg;
    logic [TIME_BITS-1:0] req_end_reg;

    logic                 cell_valid [TABLE_DEPTH];
    logic [TIME_BITS-1:0] cell_start [TABLE_DEPTH];
    logic [TIME_BITS-1:0] cell_end   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_vec;

    logic  accept_in;
    logic  out_free;
    logic  any_hit;
    logic  full;
    logic  finish;
    logic  shift_en;
    logic  m_valid_reg;
    logic  m_valid_next;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;

    // fit the fixed-width fields to the table's time width
    generate
        if (TIME_BITS <= FIELD_BITS) begin : g_trunc
            assign in_start = s_data.start_time[TIME_BITS-1:0];
            assign in_end   = s_data.end_time[TIME_BITS-1:0];
        end else begin : g_ext
            assign in_start = {{(TIME_BITS-FIELD_BITS){1'b0}}, s_data.start_time};
            assign in_end   = {{(TIME_BITS-FIELD_BITS){1'b0}}, s_data.end_time};
        end
    endgenerate

    assign s_ready   = (state_reg == S_IDLE);
    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign any_hit   = |hit_vec;
    assign full      = cell_valid[TABLE_DEPTH-1];
    assign finish    = (state_reg == S_DECIDE) && out_free;
    assign shift_en  = finish && !any_hit && !full;

    generate
        for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
            logic                 p_valid;
            logic [TIME_BITS-1:0] p_start;
            logic [TIME_BITS-1:0] p_end;
            if (i == 0) begin : g_head
                assign p_valid = 1'b1;
                assign p_start = req_start_reg;
                assign p_end   = req_end_reg;
            end else begin : g_link
                assign p_valid = cell_valid[i-1];
                assign p_start = cell_start[i-1];
                assign p_end   = cell_end[i-1];
            end
            iobt_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cap_en     (accept_in),
                .req_start  (in_start),
                .req_end    (in_end),
                .shift_en   (shift_en),
                .prev_valid (p_valid),
                .prev_start (p_start),
                .prev_end   (p_end),
                .valid      (cell_valid[i]),
                .slot_start (cell_start[i]),
                .slot_end   (cell_end[i]),
                .hit        (hit_vec[i])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        rsp_next     = rsp_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept_in) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    priority if (any_hit) begin
                        rsp_next.accepted = 1'b0;
                        rsp_next.status   = STATUS_OVERLAP;
                    end else if (full) begin
                        rsp_next.accepted = 1'b0;
                        rsp_next.status   = STATUS_FULL;
                    end else begin
                        rsp_next.accepted = 1'b1;
                        rsp_next.status   = STATUS_OK;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_reg <= rsp_next;
        if (accept_in) begin
            req_start_reg <= in_start;
            req_end_reg   <= in_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

FILE: design/iobt_cell.sv
// ----------------------------------------------------------------------------
// iobt_cell
// One table slot: holds an interval, checks a request against it, and takes
// its neighbor's interval when the chain shifts on an append.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iobt_cell #(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cap_en,
    input  logic [TIME_BITS-1:0] req_start,
    input  logic [TIME_BITS-1:0] req_end,
    input  logic                 shift_en,
    input  logic                 prev_valid,
    input  logic [TIME_BITS-1:0] prev_start,
    input  logic [TIME_BITS-1:0] prev_end,
    output logic                 valid,
    output logic [TIME_BITS-1:0] slot_start,
    output logic [TIME_BITS-1:0] slot_end,
    output logic                 hit
);

    logic                 valid_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] end_reg;
    logic                 hit_reg;
    logic                 hit_next;

    // half-open overlap test against this slot
    assign hit_next = valid_reg && (req_start < end_reg) && (req_end > start_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            if (shift_en) begin
                valid_reg <= prev_valid;
            end
            if (cap_en) begin
                hit_reg <= hit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            start_reg <= prev_start;
            end_reg   <= prev_end;
        end
    end

    assign valid      = valid_reg;
    assign slot_start = start_reg;
    assign slot_end   = end_reg;
    assign hit        = hit_reg;

endmodule
